[rtl/pipr_pkg.sv]
// Package for the point-in-polygon ray-cast core.
// Shared constants, command/status structs and the longitude wrap function.
// No dependencies.
`default_nettype none
package pipr_pkg;

  localparam int MAX_VERTICES_DEF = 1024;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [31:0] LON_WRAP = 32'd3600000000;

  typedef struct packed {
    logic clear;
    logic load;
    logic start;
    logic rd;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic stall;
    logic busy;
    logic reject;
    logic poly_hit;
    logic ovf;
  } sts_t;

  function automatic logic [31:0] wrap_lon(input logic signed [31:0] lon);
    return lon[31] ? (32'(lon) + LON_WRAP) : 32'(lon);
  endfunction

endpackage
`default_nettype wire

[rtl/point_in_polygon_ray_cast_core.sv]
// Top level of the point-in-polygon ray-cast core.
// Instantiates pipr_ctrl and pipr_dp; depends on pipr_pkg.
//
// Input channel (in_valid/in_ready) carries mode, latitude, longitude and
// ring_end. Mode clear empties the vertex store, mode load appends a vertex
// (or flags overflow when full), no result. Mode query gives one result on the
// channel (out_valid/out_ready): inside_res and dropped.
// A query walks the stored vertices through the single vertex memory read
// port, one vertex per cycle except while a ring's closing edge stalls it.
// A query outside the bounding box or with an empty store skips the walk.
// Only one query is in progress at a time; in_ready is low while it runs.
// The result sits in an output register: loads and clears are still taken
// while it waits, and a following query completes only once the previous
// result has been transferred.
// Reset (synchronous, rst_n low) empties the store, clears the box and the
// overflow flag, and drops any pending result. No clearing pass is needed.
`default_nettype none
module point_in_polygon_ray_cast_core #(
  parameter int MAX_VERTICES = pipr_pkg::MAX_VERTICES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_mode,
  input  wire logic signed [30:0] in_latitude,
  input  wire logic signed [31:0] in_longitude,
  input  wire logic               in_ring_end,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_inside_res,
  output logic                    out_dropped
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  pipr_pkg::cmd_t cmd;
  pipr_pkg::sts_t sts;
  logic [AW-1:0]  rd_addr;
  logic [CW-1:0]  total;

  pipr_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res),
    .out_dropped    (out_dropped),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .sts            (sts),
    .total          (total)
  );

  pipr_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .lat      (in_latitude),
    .lon      (in_longitude),
    .ring_end (in_ring_end),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .sts      (sts),
    .total    (total)
  );

endmodule
`default_nettype wire

[rtl/pipr_ctrl.sv]
// Controller for the point-in-polygon core: handshake, query sequencing
// and the result register. Depends on pipr_pkg.
`default_nettype none
module pipr_ctrl #(
  parameter int MAX_VERTICES = pipr_pkg::MAX_VERTICES_DEF,
  localparam int AW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_mode,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_inside_res,
  output logic                 out_dropped,
  output pipr_pkg::cmd_t       cmd,
  output logic [AW-1:0]        rd_addr,
  input  wire pipr_pkg::sts_t  sts,
  input  wire logic [CW-1:0]   total
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_START  = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_inside_r, out_inside_nxt;
  logic          out_dropped_r, out_dropped_nxt;
  logic          acc;
  logic          is_last;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign is_last  = ({{(CW-AW){1'b0}}, idx_r} == total - CW'(1));
  assign rd_addr  = idx_r;

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    out_valid_nxt   = out_valid_r;
    out_inside_nxt  = out_inside_r;
    out_dropped_nxt = out_dropped_r;
    cmd             = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_mode)
            pipr_pkg::MODE_CLEAR: cmd.clear = 1'b1;
            pipr_pkg::MODE_LOAD:  cmd.load  = 1'b1;
            pipr_pkg::MODE_QUERY: begin
              cmd.start = 1'b1;
              state_nxt = ST_START;
            end
            default: ;
          endcase
        end
        idx_nxt = '0;
      end
      ST_START: begin
        state_nxt = sts.reject ? ST_DRAIN : ST_WALK;
      end
      ST_WALK: begin
        if (!sts.stall) begin
          cmd.rd   = 1'b1;
          cmd.last = is_last;
          idx_nxt  = idx_r + AW'(1);
          if (is_last) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_inside_nxt  = sts.poly_hit && !sts.reject;
          out_dropped_nxt = sts.ovf;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_inside_r  <= out_inside_nxt;
    out_dropped_r <= out_dropped_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;
  assign out_dropped    = out_dropped_r;

endmodule
`default_nettype wire

[rtl/pipr_dp.sv]
// Datapath for the point-in-polygon core: vertex memory, bounding box,
// edge sequencing and the pipelined edge crossing test. Depends on pipr_pkg.
`default_nettype none
module pipr_dp #(
  parameter int MAX_VERTICES = pipr_pkg::MAX_VERTICES_DEF,
  localparam int AW = $clog2(MAX_VERTICES),
  localparam int CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic signed [30:0] lat,
  input  wire logic signed [31:0] lon,
  input  wire logic               ring_end,
  input  wire pipr_pkg::cmd_t     cmd,
  input  wire logic [AW-1:0]      rd_addr,
  output pipr_pkg::sts_t          sts,
  output logic [CW-1:0]           total
);

  logic signed [30:0] mem_lat [MAX_VERTICES];
  logic signed [31:0] mem_lon [MAX_VERTICES];
  logic               mem_re  [MAX_VERTICES];

  logic [CW-1:0]      total_r;
  logic               ovf_r;
  logic signed [30:0] blat_min_r, blat_max_r;
  logic signed [31:0] blon_min_r, blon_max_r;
  logic               full;
  logic               wr;

  assign full = (total_r >= CW'(MAX_VERTICES));
  assign wr   = cmd.load && !full;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      total_r    <= '0;
      ovf_r      <= 1'b0;
      blat_min_r <= '0;
      blat_max_r <= '0;
      blon_min_r <= '0;
      blon_max_r <= '0;
    end else if (cmd.load) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        total_r <= total_r + CW'(1);
        if (total_r == '0 || lat < blat_min_r) blat_min_r <= lat;
        if (total_r == '0 || lat > blat_max_r) blat_max_r <= lat;
        if (total_r == '0 || lon < blon_min_r) blon_min_r <= lon;
        if (total_r == '0 || lon > blon_max_r) blon_max_r <= lon;
      end
    end
  end

  // vertex memory, registered read
  logic signed [30:0] q_lat_r;
  logic signed [31:0] q_lon_r;
  logic               q_re_r;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_lat[total_r[AW-1:0]] <= lat;
      mem_lon[total_r[AW-1:0]] <= lon;
      mem_re[total_r[AW-1:0]]  <= ring_end;
    end
    if (cmd.rd) begin
      q_lat_r <= mem_lat[rd_addr];
      q_lon_r <= mem_lon[rd_addr];
      q_re_r  <= mem_re[rd_addr];
    end
  end

  // query point
  logic signed [30:0] plat_r;
  logic [31:0]        px_r;
  logic               reject_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      plat_r   <= lat;
      px_r     <= pipr_pkg::wrap_lon(lon);
      reject_r <= (total_r == '0) || lat < blat_min_r || lat > blat_max_r ||
                  lon < blon_min_r || lon > blon_max_r;
    end
  end

  // edge sequencing
  logic               q_vld_r, q_last_r, close_r, nfirst_r;
  logic signed [30:0] prev_lat_r, first_lat_r;
  logic signed [31:0] prev_lon_r, first_lon_r;
  logic               use_q, ring_done;
  logic               e_vld_r, e_tail_r;
  logic signed [30:0] e_alat_r, e_blat_r;
  logic signed [31:0] e_alon_r, e_blon_r;

  assign use_q     = q_vld_r && !close_r;
  assign ring_done = q_re_r || q_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r  <= 1'b0;
      close_r  <= 1'b0;
      nfirst_r <= 1'b1;
      e_vld_r  <= 1'b0;
    end else begin
      e_vld_r <= 1'b0;
      if (cmd.start) begin
        nfirst_r <= 1'b1;
      end
      if (cmd.rd) begin
        q_vld_r  <= 1'b1;
        q_last_r <= cmd.last;
      end else if (use_q) begin
        q_vld_r <= 1'b0;
      end
      if (close_r) begin
        e_vld_r  <= 1'b1;
        e_tail_r <= 1'b1;
        e_alat_r <= prev_lat_r;
        e_alon_r <= prev_lon_r;
        e_blat_r <= first_lat_r;
        e_blon_r <= first_lon_r;
        close_r  <= 1'b0;
      end else if (use_q) begin
        prev_lat_r <= q_lat_r;
        prev_lon_r <= q_lon_r;
        if (nfirst_r) begin
          first_lat_r <= q_lat_r;
          first_lon_r <= q_lon_r;
        end else begin
          e_vld_r  <= 1'b1;
          e_tail_r <= 1'b0;
          e_alat_r <= prev_lat_r;
          e_alon_r <= prev_lon_r;
          e_blat_r <= q_lat_r;
          e_blon_r <= q_lon_r;
        end
        close_r  <= ring_done;
        nfirst_r <= ring_done;
      end
    end
  end

  // stage 1: order endpoints by latitude, wrap longitudes
  logic               s1_vld_r, s1_tail_r;
  logic signed [30:0] s1_ay_r, s1_by_r;
  logic [31:0]        s1_ax_r, s1_bx_r;
  logic               swap;

  assign swap = e_alat_r > e_blat_r;

  always_ff @(posedge clk) begin
    s1_tail_r <= e_tail_r;
    s1_ay_r   <= swap ? e_blat_r : e_alat_r;
    s1_by_r   <= swap ? e_alat_r : e_blat_r;
    s1_ax_r   <= pipr_pkg::wrap_lon(swap ? e_blon_r : e_alon_r);
    s1_bx_r   <= pipr_pkg::wrap_lon(swap ? e_alon_r : e_blon_r);
  end

  // stage 2: nudge, range tests, differences
  logic               s2_vld_r, s2_tail_r;
  logic               s2_ofr_r, s2_left_r, s2_axeq_r, s2_vert_r;
  logic signed [32:0] s2_n1_r, s2_dp_r, s2_dr_r;
  logic signed [31:0] s2_n2_r;
  logic signed [31:0] py_w, py_n, ay_w, by_w;
  logic [31:0]        mx, mn;

  assign ay_w = {s1_ay_r[30], s1_ay_r};
  assign by_w = {s1_by_r[30], s1_by_r};
  assign py_w = {plat_r[30], plat_r};
  assign py_n = (plat_r == s1_ay_r || plat_r == s1_by_r) ? py_w + 32'sd1 : py_w;
  assign mx   = (s1_ax_r > s1_bx_r) ? s1_ax_r : s1_bx_r;
  assign mn   = (s1_ax_r < s1_bx_r) ? s1_ax_r : s1_bx_r;

  always_ff @(posedge clk) begin
    s2_tail_r <= s1_tail_r;
    s2_ofr_r  <= (py_n > by_w) || (py_n < ay_w) || (px_r > mx);
    s2_left_r <= px_r < mn;
    s2_axeq_r <= s1_ax_r == px_r;
    s2_vert_r <= s1_ax_r == s1_bx_r;
    s2_n1_r   <= $signed({py_n[31], py_n}) - $signed({ay_w[31], ay_w});
    s2_n2_r   <= by_w - ay_w;
    s2_dp_r   <= $signed({1'b0, px_r}) - $signed({1'b0, s1_ax_r});
    s2_dr_r   <= $signed({1'b0, s1_bx_r}) - $signed({1'b0, s1_ax_r});
  end

  // stage 3: cross products
  logic               s3_vld_r, s3_tail_r, s3_fixed_r, s3_fhit_r, s3_same_r;
  logic signed [65:0] s3_l_r, s3_r_r;
  logic               dp_pos, dr_pos;

  assign dp_pos = !s2_dp_r[32] && (s2_dp_r != '0);
  assign dr_pos = !s2_dr_r[32] && (s2_dr_r != '0);

  always_ff @(posedge clk) begin
    s3_tail_r  <= s2_tail_r;
    s3_fixed_r <= s2_ofr_r || s2_left_r || s2_axeq_r || s2_vert_r;
    s3_fhit_r  <= !s2_ofr_r && (s2_left_r || s2_axeq_r);
    s3_same_r  <= dp_pos == dr_pos;
    s3_l_r     <= 66'(s2_n1_r * s2_dr_r);
    s3_r_r     <= 66'($signed({s2_n2_r[31], s2_n2_r}) * s2_dp_r);
  end

  // stage 4: crossing decision and per-ring parity
  logic par_r, inside_r, hit;

  assign hit = s3_fixed_r ? s3_fhit_r :
               (s3_same_r ? (s3_l_r >= s3_r_r) : (s3_l_r <= s3_r_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      par_r    <= 1'b0;
      inside_r <= 1'b0;
    end else begin
      s1_vld_r <= e_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      if (cmd.start) begin
        par_r    <= 1'b0;
        inside_r <= 1'b0;
      end else if (s3_vld_r) begin
        if (s3_tail_r) begin
          inside_r <= inside_r | (par_r ^ hit);
          par_r    <= 1'b0;
        end else begin
          par_r <= par_r ^ hit;
        end
      end
    end
  end

  assign sts.stall    = close_r;
  assign sts.busy     = q_vld_r || close_r || e_vld_r || s1_vld_r || s2_vld_r || s3_vld_r;
  assign sts.reject   = reject_r;
  assign sts.poly_hit = inside_r;
  assign sts.ovf      = ovf_r;
  assign total        = total_r;

endmodule
`default_nettype wire

[rtl/pipr_checker.sv]
// Port-level checker for the point-in-polygon core, bound to the top level.
// Depends on pipr_pkg and the top-level ports.
`default_nettype none
module pipr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_mode,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_inside_res,
  input wire logic       out_dropped
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inside_res) && $stable(out_dropped))
    else $error("result changed before transfer");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == pipr_pkg::MODE_QUERY |=> !in_ready)
    else $error("input ready after query transfer");

  a_other_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode != pipr_pkg::MODE_QUERY |=> in_ready)
    else $error("input stalled after non-query transfer");

  a_result_end: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready ##1 in_ready |-> out_valid)
    else $error("query finished without a result");

endmodule

bind point_in_polygon_ray_cast_core pipr_checker u_pipr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_mode        (in_mode),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_inside_res (out_inside_res),
  .out_dropped    (out_dropped)
);
`default_nettype wire

[tb/point_in_polygon_ray_cast_core_tb.sv]
// Testbench for point_in_polygon_ray_cast_core: ring loads, clears and queries
// checked against a behavioural even-odd crossing predictor kept in the bench.
// Depends on pipr_pkg and the core RTL.
`default_nettype none
module point_in_polygon_ray_cast_core_tb;

  localparam int NV = pipr_pkg::MAX_VERTICES_DEF;
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam longint WRAP = 64'sd3600000000;

  typedef struct {
    logic inside_res;
    logic dropped;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_mode = pipr_pkg::MODE_CLEAR;
  logic signed [30:0] in_latitude = '0;
  logic signed [31:0] in_longitude = '0;
  logic in_ring_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_inside_res;
  logic out_dropped;

  longint vlat[NV];
  longint vlon[NV];
  bit vend[NV];
  int unsigned vcount;
  longint lat_lo, lat_hi, lon_lo, lon_hi;
  bit ovf;
  answer_t answers_due[$];
  int unsigned send_idle_pct, recv_idle_pct;
  int errors = 0;

  always #6 clk = ~clk;

  point_in_polygon_ray_cast_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_latitude(in_latitude),
    .in_longitude(in_longitude), .in_ring_end(in_ring_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inside_res(out_inside_res), .out_dropped(out_dropped)
  );

  function automatic longint wrapped(longint x);
    return x < 0 ? x + WRAP : x;
  endfunction

  function automatic bit crosses(longint plat, longint plon, longint alat, longint alon,
                                 longint blat, longint blon);
    longint ax, ay, bx, by, px, py, mx, mn, dp, dr, l, r;
    if (alat > blat) begin
      ax = blon; ay = blat; bx = alon; by = alat;
    end else begin
      ax = alon; ay = alat; bx = blon; by = blat;
    end
    px = wrapped(plon);
    ax = wrapped(ax);
    bx = wrapped(bx);
    py = plat;
    if (py == ay || py == by) py = py + 1;
    mx = ax > bx ? ax : bx;
    mn = ax < bx ? ax : bx;
    if (py > by || py < ay || px > mx) return 0;
    if (px < mn) return 1;
    if (ax == px) return 1;
    if (ax == bx) return 0;
    dp = px - ax;
    dr = bx - ax;
    l = (py - ay) * dr;
    r = (by - ay) * dp;
    if ((dp > 0) == (dr > 0)) return l >= r;
    return l <= r;
  endfunction

  function automatic bit point_in_rings(longint lat, longint lon);
    int unsigned first, parity;
    first = 0;
    if (vcount == 0) return 0;
    if (lat < lat_lo || lat > lat_hi || lon < lon_lo || lon > lon_hi) return 0;
    for (int unsigned i = 0; i < vcount; i++) begin
      if (vend[i] || i + 1 == vcount) begin
        parity = 0;
        for (int unsigned k = first; k <= i; k++) begin
          int unsigned n;
          n = (k == i) ? first : k + 1;
          parity ^= crosses(lat, lon, vlat[k], vlon[k], vlat[n], vlon[n]);
        end
        if (parity) return 1;
        first = i + 1;
      end
    end
    return 0;
  endfunction

  function automatic void track_item(logic [1:0] mode, longint lat, longint lon, bit re);
    answer_t a;
    case (mode)
      pipr_pkg::MODE_CLEAR: begin
        vcount = 0; ovf = 0;
        lat_lo = 0; lat_hi = 0; lon_lo = 0; lon_hi = 0;
      end
      pipr_pkg::MODE_LOAD: begin
        if (vcount >= NV) begin
          ovf = 1;
        end else begin
          if (vcount == 0) begin
            lat_lo = lat; lat_hi = lat; lon_lo = lon; lon_hi = lon;
          end else begin
            if (lat < lat_lo) lat_lo = lat;
            if (lat > lat_hi) lat_hi = lat;
            if (lon < lon_lo) lon_lo = lon;
            if (lon > lon_hi) lon_hi = lon;
          end
          vlat[vcount] = lat; vlon[vcount] = lon; vend[vcount] = re;
          vcount++;
        end
      end
      pipr_pkg::MODE_QUERY: begin
        a.inside_res = point_in_rings(lat, lon);
        a.dropped = ovf;
        answers_due.push_back(a);
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(logic [1:0] mode, longint lat, longint lon, bit re);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_latitude <= lat[30:0];
    in_longitude <= lon[31:0];
    in_ring_end <= re;
    do @(posedge clk); while (!in_ready);
    track_item(mode, lat, lon, re);
    @(negedge clk);
  endtask

  function automatic longint rnd_lat();
    return longint'($urandom_range(1800000000)) - 900000000;
  endfunction

  function automatic longint rnd_lon();
    return longint'($urandom_range(3600000000)) - 1800000000;
  endfunction

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = answers_due.pop_front();
        if (out_inside_res !== e.inside_res) begin
          $error("inside_res expected %0d actual %0d", e.inside_res, out_inside_res);
          errors++;
        end
        if (out_dropped !== e.dropped) begin
          $error("dropped expected %0d actual %0d", e.dropped, out_dropped);
          errors++;
        end
      end
    end
  end

  // ring of nv vertices on a circle around a centre, with optional random jitter
  task automatic load_ring(longint clat, longint clon, longint span, int nv, bit jitter);
    for (int i = 0; i < nv; i++) begin
      real ang;
      longint la, lo;
      ang = 6.2831853 * i / nv;
      la = clat + longint'($sin(ang) * span);
      lo = clon + longint'($cos(ang) * span);
      if (jitter) begin
        la += longint'($urandom_range(span / 4)) - span / 8;
        lo += longint'($urandom_range(span / 4)) - span / 8;
      end
      if (la > 900000000) la = 900000000;
      if (la < -900000000) la = -900000000;
      if (lo > 1800000000) lo = 1800000000;
      if (lo < -1800000000) lo = -1800000000;
      send_item(pipr_pkg::MODE_LOAD, la, lo, i == nv - 1);
    end
  endtask

  task automatic test_directed();
    send_item(pipr_pkg::MODE_QUERY, 0, 0, 0);
    send_item(pipr_pkg::MODE_LOAD, -900000000, -1800000000, 0);
    send_item(pipr_pkg::MODE_LOAD, 900000000, -1800000000, 0);
    send_item(pipr_pkg::MODE_LOAD, 900000000, 1800000000, 0);
    send_item(pipr_pkg::MODE_LOAD, -900000000, 1800000000, 1);
    send_item(pipr_pkg::MODE_QUERY, 0, 0, 0);
    send_item(pipr_pkg::MODE_QUERY, 900000000, 1800000000, 0);
    send_item(pipr_pkg::MODE_QUERY, -900000000, -1800000000, 0);
    send_item(pipr_pkg::MODE_QUERY, 0, -1, 0);
    send_item(MODE_NONE, 5, 5, 1);
    send_item(pipr_pkg::MODE_LOAD, 10, 10, 1);
    send_item(pipr_pkg::MODE_LOAD, 20, 10, 0);
    send_item(pipr_pkg::MODE_LOAD, 30, 40, 0);
    send_item(pipr_pkg::MODE_QUERY, 10, 10, 0);
    send_item(pipr_pkg::MODE_QUERY, 25, 20, 0);
    send_item(pipr_pkg::MODE_CLEAR, 0, 0, 0);
    send_item(pipr_pkg::MODE_QUERY, 0, 0, 0);
    send_item(pipr_pkg::MODE_LOAD, 100, 100, 0);
    send_item(pipr_pkg::MODE_LOAD, 300, 100, 0);
    send_item(pipr_pkg::MODE_LOAD, 200, 300, 0);
    send_item(pipr_pkg::MODE_QUERY, 200, 150, 0);
    send_item(pipr_pkg::MODE_QUERY, 100, 100, 0);
    send_item(pipr_pkg::MODE_QUERY, 200, 100, 0);
    send_item(pipr_pkg::MODE_CLEAR, 0, 0, 0);
  endtask

  task automatic test_random(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      int r;
      r = $urandom_range(9);
      if (r < 8) begin
        longint clat, clon, span;
        int nr;
        send_item(pipr_pkg::MODE_CLEAR, rnd_lat(), rnd_lon(), $urandom_range(1));
        sent++;
        nr = $urandom_range(1, 3);
        for (int k = 0; k < nr; k++) begin
          int nv;
          span = longint'($urandom_range(1000, 200000000));
          clat = rnd_lat() / 2;
          clon = rnd_lon();
          nv = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
          load_ring(clat, clon, span, nv, $urandom_range(1));
          sent += nv;
          for (int q = 0; q < 4; q++) begin
            longint ql, qo;
            ql = clat + longint'($urandom_range(2 * span)) - span;
            qo = clon + longint'($urandom_range(2 * span)) - span;
            if (ql > 900000000) ql = 900000000;
            if (ql < -900000000) ql = -900000000;
            if (qo > 1800000000) qo = 1800000000;
            if (qo < -1800000000) qo = -1800000000;
            send_item(pipr_pkg::MODE_QUERY, ql, qo, $urandom_range(1));
            sent++;
          end
        end
      end else begin
        send_item(2'($urandom_range(3)), rnd_lat(), rnd_lon(), $urandom_range(1));
        sent++;
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (NV * 2 + 50) @(posedge clk);
  endtask

  initial begin
    vcount = 0; ovf = 0;
    lat_lo = 0; lat_hi = 0; lon_lo = 0; lon_hi = 0;
    send_idle_pct = 13;
    recv_idle_pct = 68;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(200);
    send_idle_pct = 68;
    recv_idle_pct = 13;
    test_random(150);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150);
    drain();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #60000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
